### rtl/core/neighbor_link_table_defines.svh
// assertion macros shared by the neighbor link table rtl
// depends on nothing; included by modules that carry assertions
`ifndef NEIGHBOR_LINK_TABLE_DEFINES_SVH
`define NEIGHBOR_LINK_TABLE_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define NLT_ASSERT_IMPL(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// next-cycle implication checked outside reset
`define NLT_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

### rtl/core/nlt_pkg.sv
// package for the neighbor link table: opcodes, status codes, states
// no dependencies
`timescale 1ns / 1ps

package nlt_pkg;

    localparam logic [2:0] OP_RX     = 3'd0;
    localparam logic [2:0] OP_TX     = 3'd1;
    localparam logic [2:0] OP_QUERY  = 3'd2;
    localparam logic [2:0] OP_MRD    = 3'd3;
    localparam logic [2:0] OP_MWR    = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    localparam logic [1:0] REG_PROMOTE = 2'd0;
    localparam logic [1:0] REG_DEMOTE  = 2'd1;
    localparam logic [1:0] REG_SWITCH  = 2'd2;

    localparam logic [63:0] ADDR_BROADCAST = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [15:0] MASK_NONE      = 16'hFFFF;
    localparam logic [7:0]  COUNT_MAX      = 8'd255;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_READ,
        S_UPDATE,
        S_RESULT
    } nlt_state_t;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [63:0] peer_address;
        logic [7:0]  rx_rssi;
        logic [39:0] slot_timestamp;
        logic [7:0]  tx_attempts;
        logic        tx_acked;
        logic [15:0] new_channel_mask;
    } nlt_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        row_found;
        logic [3:0]  row_index;
        logic        is_stable;
        logic [15:0] channel_mask;
    } nlt_out_t;

    // per-row record kept in ram (address held apart for the search)
    typedef struct packed {
        logic [7:0]  rssi;
        logic        stable;
        logic [7:0]  switch_counter;
        logic [7:0]  rx_count;
        logic [7:0]  tx_count;
        logic [7:0]  ack_count;
        logic [39:0] last_heard;
        logic [15:0] channel_mask;
    } nlt_row_t;

    typedef struct packed {
        logic [1:0] index;
        logic [7:0] data;
    } nlt_cfg_t;

endpackage

### rtl/core/nlt_if.sv
// valid/ready channel interfaces for the neighbor link table
// depends on nlt_pkg
`timescale 1ns / 1ps

interface nlt_in_if;
    import nlt_pkg::*;
    logic    valid;
    logic    ready;
    nlt_in_t payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface nlt_out_if;
    import nlt_pkg::*;
    logic     valid;
    logic     ready;
    nlt_out_t payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface nlt_cfg_if;
    import nlt_pkg::*;
    logic     valid;
    logic     ready;
    nlt_cfg_t payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### rtl/core/nlt_ram.sv
// generic single-port-write ram with registered read
// no dependencies
`timescale 1ns / 1ps

module nlt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

### rtl/core/nlt_row_update.sv
// row update datapath: receive hysteresis, transmit counters, mask write
// depends on nlt_pkg
`timescale 1ns / 1ps

module nlt_row_update (
    input  nlt_pkg::nlt_in_t  item,
    input  nlt_pkg::nlt_row_t row_in,
    input  logic              allocate,
    input  logic [7:0]        promote_th,
    input  logic [7:0]        demote_th,
    input  logic [7:0]        switch_count,
    output nlt_pkg::nlt_row_t row_out
);
    import nlt_pkg::*;

    logic       qualifies;
    logic [7:0] sw_inc;
    logic [7:0] tx_base;
    logic [7:0] ack_base;
    logic [8:0] tx_sum;

    always_comb
    begin
        row_out   = row_in;
        qualifies = row_in.stable
            ? ($signed(item.rx_rssi) < $signed(demote_th))
            : ($signed(item.rx_rssi) > $signed(promote_th));
        sw_inc    = row_in.switch_counter + 8'd1;
        tx_base   = (row_in.tx_count == COUNT_MAX) ? {1'b0, row_in.tx_count[7:1]}
                                                   : row_in.tx_count;
        ack_base  = (row_in.tx_count == COUNT_MAX) ? {1'b0, row_in.ack_count[7:1]}
                                                   : row_in.ack_count;
        tx_sum    = {1'b0, tx_base} + {1'b0, item.tx_attempts};
        if (allocate)
        begin
            // fresh row; the mask keeps its stored value
            row_out.stable         = 1'b1;
            row_out.switch_counter = 8'd0;
            row_out.rssi           = item.rx_rssi;
            row_out.rx_count       = 8'd1;
            row_out.tx_count       = 8'd0;
            row_out.ack_count      = 8'd0;
            row_out.last_heard     = item.slot_timestamp;
        end
        else
        begin
            case (item.opcode)
                OP_RX:
                begin
                    row_out.rx_count   = row_in.rx_count + 8'd1;
                    row_out.rssi       = item.rx_rssi;
                    row_out.last_heard = item.slot_timestamp;
                    if (!qualifies)
                    begin
                        row_out.switch_counter = 8'd0;
                    end
                    else if (sw_inc >= switch_count)
                    begin
                        row_out.switch_counter = 8'd0;
                        row_out.stable         = !row_in.stable;
                    end
                    else
                    begin
                        row_out.switch_counter = sw_inc;
                    end
                end
                OP_TX:
                begin
                    row_out.tx_count  = tx_sum[8] ? COUNT_MAX : tx_sum[7:0];
                    row_out.ack_count = ack_base;
                    if (item.tx_acked)
                    begin
                        if (ack_base != COUNT_MAX)
                        begin
                            row_out.ack_count = ack_base + 8'd1;
                        end
                        row_out.last_heard = item.slot_timestamp;
                    end
                end
                OP_MWR:
                begin
                    row_out.channel_mask = item.new_channel_mask;
                end
                default:
                begin
                    row_out = row_in;
                end
            endcase
        end
    end
endmodule

### rtl/core/neighbor_link_table.sv
// neighbor link table top level: sequencer, address search, row ram
// depends on nlt_pkg, nlt_if, nlt_ram, nlt_row_update, defines header
//
//  channel   dir   contents
//  in_ch     sink  opcode, address, rssi, timestamp, tx fields, new mask
//  out_ch    src   status, row_found, row_index, is_stable, channel_mask
//  cfg_ch    sink  register index, 8-bit data
//
// the address search reads one row a cycle from the address ram into a single
// 64-bit comparator (the read is registered), then one row ram read and one
// write.
// in_ch is ready only when idle; the result sits in a register until taken.
// reset clears the used bits and the mask-written bits; no clearing pass.
// cfg_ch is always ready.
`timescale 1ns / 1ps
`include "neighbor_link_table_defines.svh"

module neighbor_link_table #(
    parameter int TABLE_ROWS = 16
) (
    input logic      clk,
    input logic      rst_n,
    nlt_in_if.sink   in_ch,
    nlt_out_if.source out_ch,
    nlt_cfg_if.sink  cfg_ch
);
    import nlt_pkg::*;

    localparam int RW = $clog2(TABLE_ROWS);

    nlt_state_t state_reg, state_next;
    nlt_in_t    item_reg;
    nlt_out_t   result_reg, result_next;
    logic [RW:0]  scan_reg, scan_next;
    logic         hit_reg, hit_next;
    logic         free_ok_reg, free_ok_next;
    logic [RW-1:0] hit_row_reg, hit_row_next, free_row_reg, free_row_next;
    logic [TABLE_ROWS-1:0] used_reg, mask_set_reg;
    logic [7:0]   promote_reg, demote_reg, switch_reg;

    logic [RW-1:0] row_sel, scan_idx, cmp_idx;
    logic          allocate, do_write, row_match;
    nlt_row_t      rd_row, rd_fixed, wr_row;
    logic [63:0]   addr_rd;

    // scan_idx is the address read issued, cmp_idx the row now on addr_rd
    assign scan_idx = scan_reg[RW-1:0];
    assign cmp_idx  = scan_idx - 1'b1;
    assign row_match = used_reg[cmp_idx] && (addr_rd == item_reg.peer_address);
    assign allocate = !hit_reg && free_ok_reg && (item_reg.opcode == OP_RX)
        && (item_reg.peer_address != ADDR_BROADCAST);
    assign row_sel  = hit_reg ? hit_row_reg : free_row_reg;

    // mask reads as all ones until first written
    always_comb
    begin
        rd_fixed = rd_row;
        if (!mask_set_reg[row_sel])
        begin
            rd_fixed.channel_mask = MASK_NONE;
        end
    end

    nlt_row_update u_update (
        .item         (item_reg),
        .row_in       (rd_fixed),
        .allocate     (allocate),
        .promote_th   (promote_reg),
        .demote_th    (demote_reg),
        .switch_count (switch_reg),
        .row_out      (wr_row)
    );

    assign do_write = (state_reg == S_UPDATE) && (hit_reg || allocate)
        && (item_reg.opcode <= OP_MWR);

    nlt_ram #(
        .WIDTH ($bits(nlt_row_t)),
        .DEPTH (TABLE_ROWS)
    ) u_rows (
        .clk     (clk),
        .wr_en   (do_write),
        .wr_addr (row_sel),
        .wr_data (wr_row),
        .rd_addr (row_sel),
        .rd_data (rd_row)
    );

    // address store, searched one row a cycle
    nlt_ram #(
        .WIDTH (64),
        .DEPTH (TABLE_ROWS)
    ) u_addrs (
        .clk     (clk),
        .wr_en   (do_write && allocate),
        .wr_addr (row_sel),
        .wr_data (item_reg.peer_address),
        .rd_addr (scan_idx),
        .rd_data (addr_rd)
    );

    assign in_ch.ready  = (state_reg == S_IDLE);
    assign out_ch.valid = (state_reg == S_RESULT);
    assign out_ch.payload = result_reg;
    assign cfg_ch.ready = 1'b1;

    // sequencer next state and result
    always_comb
    begin
        state_next   = state_reg;
        scan_next    = scan_reg;
        hit_next     = hit_reg;
        hit_row_next = hit_row_reg;
        free_ok_next = free_ok_reg;
        free_row_next = free_row_reg;
        result_next  = result_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    state_next   = S_SCAN;
                    scan_next    = '0;
                    hit_next     = 1'b0;
                    free_ok_next = 1'b0;
                    hit_row_next = '0;
                    free_row_next = '0;
                end
            end
            S_SCAN:
            begin
                if (scan_reg != '0)
                begin
                    if (row_match && !hit_reg
                        && (item_reg.peer_address != ADDR_BROADCAST))
                    begin
                        hit_next     = 1'b1;
                        hit_row_next = cmp_idx;
                    end
                    if (!used_reg[cmp_idx] && !free_ok_reg)
                    begin
                        free_ok_next  = 1'b1;
                        free_row_next = cmp_idx;
                    end
                end
                if (scan_reg == (RW+1)'(TABLE_ROWS))
                begin
                    state_next = S_READ;
                end
                scan_next = scan_reg + 1'b1;
            end
            S_READ:
            begin
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                state_next = S_RESULT;
                result_next.row_found    = hit_reg && (item_reg.opcode <= OP_MWR);
                if (do_write)
                begin
                    result_next.status       = ST_OK;
                    result_next.row_index    = 4'(row_sel);
                    result_next.is_stable    = wr_row.stable;
                    result_next.channel_mask = wr_row.channel_mask;
                end
                else
                begin
                    result_next.status = (item_reg.opcode == OP_RX
                        && item_reg.peer_address != ADDR_BROADCAST && !hit_reg)
                        ? ST_FULL : ST_NOT_FOUND;
                    result_next.row_index    = 4'd0;
                    result_next.is_stable    = 1'b0;
                    result_next.channel_mask = MASK_NONE;
                end
            end
            S_RESULT:
            begin
                if (out_ch.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            scan_reg     <= '0;
            hit_reg      <= 1'b0;
            free_ok_reg  <= 1'b0;
            used_reg     <= '0;
            mask_set_reg <= '0;
            promote_reg  <= 8'hBA;
            demote_reg   <= 8'hA6;
            switch_reg   <= 8'd3;
        end
        else
        begin
            state_reg   <= state_next;
            scan_reg    <= scan_next;
            hit_reg     <= hit_next;
            free_ok_reg <= free_ok_next;
            if (do_write)
            begin
                used_reg[row_sel] <= 1'b1;
                if (item_reg.opcode == OP_MWR)
                begin
                    mask_set_reg[row_sel] <= 1'b1;
                end
            end
            if (cfg_ch.valid)
            begin
                case (cfg_ch.payload.index)
                    REG_PROMOTE: promote_reg <= cfg_ch.payload.data;
                    REG_DEMOTE:  demote_reg  <= cfg_ch.payload.data;
                    REG_SWITCH:  switch_reg  <= cfg_ch.payload.data;
                    default:     promote_reg <= promote_reg;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        hit_row_reg  <= hit_row_next;
        free_row_reg <= free_row_next;
        result_reg   <= result_next;
        if (in_ch.valid && in_ch.ready)
        begin
            item_reg <= in_ch.payload;
        end
    end

    `NLT_ASSERT_IMPL(a_ready_idle, clk, rst_n, in_ch.ready, !out_ch.valid)
    `NLT_ASSERT_NEXT(a_scan_to_read, clk, rst_n,
        (state_reg == S_SCAN) && (scan_reg == (RW+1)'(TABLE_ROWS)),
        state_reg == S_READ)
    `NLT_ASSERT_IMPL(a_write_target, clk, rst_n, do_write && !allocate, hit_reg)
endmodule
